/* sv/iges_pkg.sv */
// Shared types and constants for the ideal gas equation of state unit.
`timescale 1ns / 1ps
`default_nettype none
package iges_pkg;

    localparam int VALUE_W    = 32;
    localparam int GAMMA_W    = 15;
    localparam int GAMMA_FRAC = 12;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 15'd4096;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 15'd5734;

    localparam logic MODE_APPLY = 1'b0;
    localparam logic MODE_INIT  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] density;
        logic [VALUE_W-1:0] energy_or_pressure;
    } t_eos_in;

    typedef struct packed {
        logic [VALUE_W-1:0] pressure_or_energy;
        logic [VALUE_W-1:0] wave_speed;
        logic [VALUE_W-1:0] pressure_energy_slope;
        logic               zero_density;
        logic               saturated;
    } t_eos_out;

endpackage
`default_nettype wire

/* sv/ideal_gas_eos_unit_top.sv */
// Ideal gas equation of state: pipelined pressure, energy, slope and sound speed.
// Throughput: one beat per cycle unless the output stalls; one-bit-per-stage divider and square root stages set depth.
// Reset: synchronous active-low, clears valid bits and loads adiabatic index 5734.
// The whole pipeline holds while the output beat is not taken.
`timescale 1ns / 1ps
`default_nettype none
module ideal_gas_eos_unit_top #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [14:0]               i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  iges_pkg::t_eos_in        i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output iges_pkg::t_eos_out       o_out_data
);
    import iges_pkg::*;

    localparam int W  = VALUE_W;
    localparam int F  = FRACTION_BITS;
    localparam int G  = GAMMA_FRAC;
    localparam int GW = GAMMA_W;
    localparam int DW = W + GW;
    localparam int SH = 2 * F - G;
    localparam int NS = W + GW + SH;
    localparam int NE = W + F + G;
    localparam int ND = (NS > NE) ? NS : NE;
    localparam int QX = (ND > 2 * W) ? ND : 2 * W;
    localparam int RW = W + 2;
    localparam int XW = 2 * W + GW;
    localparam logic [W-1:0] VMAX = {W{1'b1}};

    typedef struct packed {
        logic          mode;
        logic          zr;
        logic          bz;
        logic          xnz;
        logic          sat;
        logic [W-1:0]  p;
        logic [W-1:0]  slope;
        logic [W-1:0]  rho;
        logic [DW-1:0] a;
    } t_side;

    typedef struct packed {
        t_side          sd;
        logic [DW-1:0]  srem;
        logic [ND-1:0]  snq;
        logic [DW-1:0]  erem;
        logic [ND-1:0]  enq;
    } t_div;

    typedef struct packed {
        logic [W-1:0]     first;
        logic [W-1:0]     slope;
        logic             zr;
        logic             sat;
        logic             csat;
        logic [RW-1:0]    rem;
        logic [W-1:0]     root;
        logic [2*W-1:0]   qv;
    } t_sq;

    function automatic logic [DW+ND-1:0] f_div(
        input logic [DW-1:0] rem,
        input logic [ND-1:0] nq,
        input logic [DW-1:0] d
    );
        logic [DW:0]   t;
        logic [DW:0]   dd;
        logic          ge;
        logic [DW-1:0] nrem;
        t    = {rem, nq[ND-1]};
        dd   = {1'b0, d};
        ge   = (t >= dd);
        nrem = ge ? DW'(t - dd) : DW'(t);
        return {nrem, nq[ND-2:0], ge};
    endfunction

    function automatic t_sq f_sqrt(input t_sq s);
        t_sq           o;
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic          ge;
        o     = s;
        t     = {s.rem, s.qv[2*W-1 -: 2]};
        trial = (RW+2)'({s.root, 2'b01});
        ge    = (t >= trial);
        o.rem  = ge ? RW'(t - trial) : RW'(t);
        o.root = {s.root[W-2:0], ge};
        o.qv   = {s.qv[2*W-3:0], 2'b00};
        return o;
    endfunction

    logic [GW-1:0] r_gamma;
    logic [GW-1:0] w_gm1;
    logic          w_adv;

    logic          r1_vld, r1_mode;
    logic [W-1:0]  r1_rho, r1_x;
    logic [DW-1:0] r1_a, n1_a;

    logic           r2_vld, r2_mode;
    logic [W-1:0]   r2_rho, r2_x;
    logic [DW-1:0]  r2_a;
    logic [2*W-1:0] r2_pl, n2_pl;
    logic [W+GW-1:0] r2_ph, n2_ph;

    logic          r3_vld;
    t_side         r3_sd, n3_sd;
    logic [XW-1:0] w3_ax;

    logic [W-1:0]    w4_sel;
    logic [W+GW-1:0] w4_gp;
    t_div            n_d  [ND+1];
    t_div            r_d  [ND+1];
    logic [ND:0]     r_dv;

    t_sq             n_s  [W+1];
    t_sq             r_s  [W+1];
    logic [W:0]      r_sv;
    logic [QX:0]     w_qx;
    logic            w_cover;
    logic            w_eover;

    t_eos_out        r_out, n_out;
    logic            r_ov;

    assign o_cfg_ready = 1'b1;
    assign w_gm1       = (r_gamma > GAMMA_ONE) ? (r_gamma - GAMMA_ONE) : '0;
    assign w_adv       = !r_ov || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_valid) begin
            r_gamma <= i_cfg_data;
        end
    end

    always_comb begin
        n1_a  = DW'(i_in_data.density) * DW'(w_gm1);
        n2_pl = (2*W)'(r1_a[W-1:0]) * (2*W)'(r1_x);
        n2_ph = (W+GW)'(r1_a[DW-1:W]) * (W+GW)'(r1_x);
        w3_ax = XW'(r2_pl) + (XW'(r2_ph) << W);

        n3_sd       = '0;
        n3_sd.mode  = r2_mode;
        n3_sd.zr    = (r2_rho == '0);
        n3_sd.bz    = (r2_a == '0);
        n3_sd.xnz   = (r2_x != '0);
        n3_sd.rho   = r2_rho;
        n3_sd.a     = r2_a;
        n3_sd.p     = r2_x;
        if (r2_mode == MODE_APPLY) begin
            n3_sd.p     = (|w3_ax[XW-1:G+F+W]) ? VMAX : w3_ax[G+F +: W];
            n3_sd.slope = (|r2_a[DW-1:W+G]) ? VMAX : r2_a[G +: W];
            n3_sd.sat   = (|w3_ax[XW-1:G+F+W]) || (|r2_a[DW-1:W+G]);
        end

        w4_sel = r3_sd.p;
        w4_gp  = (W+GW)'(w4_sel) * (W+GW)'(r_gamma);
        n_d[0].sd   = r3_sd;
        n_d[0].srem = '0;
        n_d[0].snq  = ND'(w4_gp) << SH;
        n_d[0].erem = '0;
        n_d[0].enq  = ND'(r3_sd.p) << (F + G);
        for (int k = 1; k <= ND; k++) begin
            n_d[k].sd = r_d[k-1].sd;
            {n_d[k].srem, n_d[k].snq} = f_div(r_d[k-1].srem, r_d[k-1].snq,
                                              DW'(r_d[k-1].sd.rho));
            {n_d[k].erem, n_d[k].enq} = f_div(r_d[k-1].erem, r_d[k-1].enq,
                                              r_d[k-1].sd.a);
        end

        w_qx    = (QX+1)'(r_d[ND].snq);
        w_cover = |w_qx[QX:2*W];
        w_eover = |r_d[ND].enq[ND-1:W];
        n_s[0]       = '0;
        n_s[0].slope = r_d[ND].sd.slope;
        n_s[0].zr    = r_d[ND].sd.zr;
        n_s[0].csat  = !r_d[ND].sd.zr && w_cover;
        n_s[0].qv    = (r_d[ND].sd.zr || w_cover) ? '0 : w_qx[2*W-1:0];
        n_s[0].sat   = r_d[ND].sd.sat || n_s[0].csat;
        if (r_d[ND].sd.mode == MODE_APPLY) begin
            n_s[0].first = r_d[ND].sd.p;
        end else if (r_d[ND].sd.zr) begin
            n_s[0].first = '0;
        end else if (r_d[ND].sd.bz) begin
            n_s[0].first = r_d[ND].sd.xnz ? VMAX : '0;
            n_s[0].sat   = n_s[0].sat || r_d[ND].sd.xnz;
        end else begin
            n_s[0].first = w_eover ? VMAX : r_d[ND].enq[W-1:0];
            n_s[0].sat   = n_s[0].sat || w_eover;
        end
        for (int k = 1; k <= W; k++) begin
            n_s[k] = f_sqrt(r_s[k-1]);
        end

        n_out.pressure_or_energy    = r_s[W].first;
        n_out.wave_speed            = r_s[W].zr ? '0 : (r_s[W].csat ? VMAX : r_s[W].root);
        n_out.pressure_energy_slope = r_s[W].slope;
        n_out.zero_density          = r_s[W].zr;
        n_out.saturated             = r_s[W].sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_dv   <= '0;
            r_sv   <= '0;
            r_ov   <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_dv   <= {r_dv[ND-1:0], r3_vld};
            r_sv   <= {r_sv[W-1:0], r_dv[ND]};
            r_ov   <= r_sv[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mode <= i_in_data.mode;
            r1_rho  <= i_in_data.density;
            r1_x    <= i_in_data.energy_or_pressure;
            r1_a    <= n1_a;
            r2_mode <= r1_mode;
            r2_rho  <= r1_rho;
            r2_x    <= r1_x;
            r2_a    <= r1_a;
            r2_pl   <= n2_pl;
            r2_ph   <= n2_ph;
            r3_sd   <= n3_sd;
            for (int k = 0; k <= ND; k++) begin
                r_d[k] <= n_d[k];
            end
            for (int k = 0; k <= W; k++) begin
                r_s[k] <= n_s[k];
            end
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the ideal gas equation of state unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import iges_pkg::*;

    localparam int FRAC = 16;
    localparam int DRAIN = 140;
    localparam int WD_LIMIT = 20000;
    localparam logic [VALUE_W-1:0] VMAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [14:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_eos_in i_in_data = '0;
    wire o_cfg_ready, o_in_ready, o_out_valid;
    t_eos_out o_out_data;

    ideal_gas_eos_unit_top #(.FRACTION_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    t_eos_in cell_q[$];
    t_eos_out eos_expect_q[$];
    logic [GAMMA_W-1:0] gamma_cur = GAMMA_RESET;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    // floor(sqrt(g*p/rho)) with saturation; rho nonzero
    function automatic logic [VALUE_W-1:0] wave_speed_of(
        logic [14:0] g, logic [VALUE_W-1:0] p, logic [VALUE_W-1:0] rho, ref logic sat);
        logic [255:0] num, q, sq;
        logic [VALUE_W-1:0] res, cand;
        num = (256'(p) * 256'(g)) << (2 * FRAC - GAMMA_FRAC);
        q = num / 256'(rho);
        res = '0;
        if (q >= (256'd1 << (2 * VALUE_W))) begin
            sat = 1'b1;
            return VMAX;
        end
        for (int b = VALUE_W - 1; b >= 0; b--) begin
            cand = res | (VALUE_W'(1) << b);
            sq = 256'(cand) * 256'(cand);
            if (sq <= q) res = cand;
        end
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] clamp_value(logic [255:0] v, ref logic sat);
        if (v > 256'(VMAX)) begin
            sat = 1'b1;
            return VMAX;
        end
        return v[VALUE_W-1:0];
    endfunction

    function automatic t_eos_out eos_of(t_eos_in c, logic [14:0] g);
        t_eos_out r;
        logic sat;
        logic [255:0] gm1, a, b;
        sat = 1'b0;
        r = '0;
        gm1 = (g > GAMMA_ONE) ? 256'(g - GAMMA_ONE) : '0;
        r.zero_density = (c.density == 0);
        if (c.mode == MODE_APPLY) begin
            a = 256'(c.density) * gm1;
            b = (a * 256'(c.energy_or_pressure)) >> (GAMMA_FRAC + FRAC);
            r.pressure_or_energy = clamp_value(b, sat);
            r.pressure_energy_slope = clamp_value(a >> GAMMA_FRAC, sat);
            if (c.density != 0)
                r.wave_speed = wave_speed_of(g, r.pressure_or_energy, c.density, sat);
        end else if (c.density != 0) begin
            b = 256'(c.density) * gm1;
            if (b == 0) begin
                if (c.energy_or_pressure != 0) begin
                    r.pressure_or_energy = VMAX;
                    sat = 1'b1;
                end
            end else begin
                a = 256'(c.energy_or_pressure) << (FRAC + GAMMA_FRAC);
                r.pressure_or_energy = clamp_value(a / b, sat);
            end
            r.wave_speed = wave_speed_of(g, c.energy_or_pressure, c.density, sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VMAX;
            2: return VALUE_W'($urandom_range(0, 255));
            3: return VALUE_W'($urandom_range(1, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (cell_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_data <= cell_q[0];
                    i_in_valid <= 1'b1;
                    eos_expect_q.push_back(eos_of(cell_q[0], gamma_cur));
                    void'(cell_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_eos_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (eos_expect_q.size() == 0) begin
                $error("unexpected result beat %h", o_out_data);
                errors++;
            end else begin
                exp_r = eos_expect_q.pop_front();
                if (o_out_data.pressure_or_energy !== exp_r.pressure_or_energy) begin
                    $error("pressure_or_energy exp %h got %h",
                           exp_r.pressure_or_energy, o_out_data.pressure_or_energy);
                    errors++;
                end
                if (o_out_data.wave_speed !== exp_r.wave_speed) begin
                    $error("wave_speed exp %h got %h",
                           exp_r.wave_speed, o_out_data.wave_speed);
                    errors++;
                end
                if (o_out_data.pressure_energy_slope !== exp_r.pressure_energy_slope) begin
                    $error("pressure_energy_slope exp %h got %h",
                           exp_r.pressure_energy_slope, o_out_data.pressure_energy_slope);
                    errors++;
                end
                if (o_out_data.zero_density !== exp_r.zero_density) begin
                    $error("zero_density exp %b got %b",
                           exp_r.zero_density, o_out_data.zero_density);
                    errors++;
                end
                if (o_out_data.saturated !== exp_r.saturated) begin
                    $error("saturated exp %b got %b", exp_r.saturated, o_out_data.saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    task automatic push_cell(logic m, logic [VALUE_W-1:0] rho, logic [VALUE_W-1:0] x);
        t_eos_in c;
        c.mode = m;
        c.density = rho;
        c.energy_or_pressure = x;
        cell_q.push_back(c);
    endtask

    task automatic wait_drained();
        while (cell_q.size() != 0 || i_in_valid || eos_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_gamma(logic [14:0] g);
        i_cfg_data <= g;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        gamma_cur = g;
    endtask

    task automatic random_cells(int n);
        for (int k = 0; k < n; k++)
            push_cell(1'($urandom_range(0, 1)), rand_value(), rand_value());
    endtask

    initial begin
        logic [14:0] gammas[6];
        gammas = '{15'd4097, 15'd32767, 15'd5734, 15'd4096, 15'd0, 15'd6827};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_cell(MODE_APPLY, 32'h0001_0000, 32'h0001_0000);
        push_cell(MODE_INIT, 32'h0001_0000, 32'h0001_0000);
        push_cell(MODE_APPLY, '0, 32'h1234_5678);
        push_cell(MODE_INIT, '0, 32'h1234_5678);
        push_cell(MODE_APPLY, VMAX, VMAX);
        push_cell(MODE_INIT, VMAX, VMAX);
        push_cell(MODE_INIT, 32'd1, VMAX);
        push_cell(MODE_APPLY, 32'd1, 32'd1);
        push_cell(MODE_INIT, 32'd1, 32'd0);
        push_cell(MODE_APPLY, 32'hAAAA_AAAA, 32'h5555_5555);
        push_cell(MODE_INIT, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        foreach (gammas[i]) begin
            write_gamma(gammas[i]);
            push_cell(MODE_INIT, 32'h0002_0000, 32'h0003_0000);
            push_cell(MODE_INIT, 32'h0002_0000, '0);
            push_cell(MODE_APPLY, VMAX, VMAX);
            case (i)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 67; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 67; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                4: begin send_idle_pct = 0; recv_stall_pct = 0; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 400; end
            endcase
            random_cells(i == 5 ? 800 : 240);
            wait_drained();
        end
        write_gamma(15'($urandom_range(4097, 32767)));
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_cells(200);
        wait_drained();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
